/* rtl/core/bdil_pkg.sv */
// ----------------------------------------------------------------------------
// bdil_pkg
// Shared widths, codes and structs of the 3x3 binary dilation block.
// ----------------------------------------------------------------------------
package bdil_pkg;

	localparam int ROW_W     = 10;
	localparam int COL_W     = 10;
	localparam int PIX_W     = 16;
	localparam int DIL_W     = 8;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 1;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 11'd1024;
	localparam logic [PIX_W-1:0] FG_PIXEL       = 16'd255;
	localparam logic [DIL_W-1:0] DIL_FG         = 8'd255;
	localparam logic [DIL_W-1:0] DIL_BG         = 8'd0;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMG_WIDTH  = 1'b0,
		REG_IMG_HEIGHT = 1'b1
	} cfg_reg_t;

	// neighbour offset along one axis: -1, 0, +1
	typedef enum logic [1:0] {
		OFS_NEG  = 2'd0,
		OFS_ZERO = 2'd1,
		OFS_POS  = 2'd2
	} ofs_t;

	// coordinate request to the address unit
	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		ofs_t             dr;
		ofs_t             dc;
	} addr_req_t;

	// access request to the bit store
	typedef struct packed {
		logic we;
		logic re;
		logic wbit;
	} mem_req_t;

endpackage

/* rtl/core/bdil_in_if.sv */
// ----------------------------------------------------------------------------
// bdil_in_if
// Input channel: write or query transactions with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bdil_in_if;
	logic                      valid;
	logic                      ready;
	logic                      cmd;
	logic [bdil_pkg::ROW_W-1:0] row;
	logic [bdil_pkg::COL_W-1:0] col;
	logic [bdil_pkg::PIX_W-1:0] pixel;

	modport source (output valid, output cmd, output row, output col, output pixel,
		input ready);
	modport sink (input valid, input cmd, input row, input col, input pixel,
		output ready);
endinterface

/* rtl/core/bdil_out_if.sv */
// ----------------------------------------------------------------------------
// bdil_out_if
// Output channel: dilation results with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bdil_out_if;
	logic                       valid;
	logic                       ready;
	logic [bdil_pkg::DIL_W-1:0] dilated;

	modport source (output valid, output dilated, input ready);
	modport sink (input valid, input dilated, output ready);
endinterface

/* rtl/core/binary_dilation_3x3.sv */
// ----------------------------------------------------------------------------
// binary_dilation_3x3
// 3x3 binary dilation over a stored image with clamped borders.
// ----------------------------------------------------------------------------
// Usage:
//  - in_ch carries transactions: cmd write stores one foreground bit
//    (pixel == 255) at row/col, cmd query asks for the dilated pixel there.
//  - out_ch returns one dilated value (255 or 0) per query; writes return
//    nothing. Writes outside img_width x img_height are dropped, queries
//    outside it answer 0.
//  - cfg_we/cfg_idx/cfg_wdata set img_width (index 0) and img_height
//    (index 1); write them only while the block is idle.
// Timing:
//  - A write is stored at acceptance; in_ch is ready again at once.
//  - An in-image query reads its nine neighbours one per cycle through the
//    single store port and the shared clamp/address unit (ST_READ), folds
//    the last bit into the result register (ST_DONE) and then returns to
//    idle to take the next transaction; an outside query skips ST_READ.
//  - If out_ch stalls, the result register holds its value; writes keep
//    flowing, and a following query waits at its end until the register
//    frees.
// Reset: clears control state and sets both sizes to 1024. The store is
//  not cleared; pixels must be written before a query touches them.
// ----------------------------------------------------------------------------
module binary_dilation_3x3 #(
	parameter int MAX_WIDTH  = bdil_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bdil_pkg::DEF_MAX_HEIGHT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	bdil_in_if.sink                        in_ch,
	bdil_out_if.source                     out_ch,
	input  logic                           cfg_we,
	input  logic [bdil_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [bdil_pkg::CFG_W-1:0]     cfg_wdata
);
	import bdil_pkg::*;

	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int HW    = $clog2(MAX_HEIGHT + 1);
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	logic [CFG_W-1:0] img_width_q;
	logic [CFG_W-1:0] img_height_q;
	logic [WW-1:0]    eff_w;
	logic [HW-1:0]    eff_h;

	addr_req_t     areq;
	mem_req_t      mreq;
	logic [AW-1:0] addr;
	logic          in_img;
	logic          rdata;

	// size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_width_q  <= CFG_SIZE_RESET;
			img_height_q <= CFG_SIZE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_idx))
				REG_IMG_WIDTH:  img_width_q  <= cfg_wdata;
				REG_IMG_HEIGHT: img_height_q <= cfg_wdata;
			endcase
		end
	end

	// zero counts as 1, anything above the store size saturates
	always_comb begin
		if (img_width_q == '0) begin
			eff_w = WW'(1);
		end else if (int'(img_width_q) > MAX_WIDTH) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(img_width_q);
		end
		if (img_height_q == '0) begin
			eff_h = HW'(1);
		end else if (int'(img_height_q) > MAX_HEIGHT) begin
			eff_h = HW'(MAX_HEIGHT);
		end else begin
			eff_h = HW'(img_height_q);
		end
	end

	bdil_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.in_img (in_img),
		.rdata  (rdata),
		.areq   (areq),
		.mreq   (mreq)
	);

	bdil_addr #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.WW         (WW),
		.HW         (HW),
		.AW         (AW)
	) u_addr (
		.req    (areq),
		.eff_w  (eff_w),
		.eff_h  (eff_h),
		.addr   (addr),
		.in_img (in_img)
	);

	bdil_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.req   (mreq),
		.addr  (addr),
		.rdata (rdata)
	);

endmodule

/* rtl/core/bdil_addr.sv */
// ----------------------------------------------------------------------------
// bdil_addr
// Shared address unit: clamps one neighbour coordinate to the image edges
// and forms the linear store address row*MAX_WIDTH+col.
// ----------------------------------------------------------------------------
module bdil_addr #(
	parameter int MAX_WIDTH  = bdil_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bdil_pkg::DEF_MAX_HEIGHT,
	parameter int WW         = $clog2(MAX_WIDTH + 1),
	parameter int HW         = $clog2(MAX_HEIGHT + 1),
	parameter int AW         = $clog2(MAX_WIDTH * MAX_HEIGHT)
) (
	input  bdil_pkg::addr_req_t req,
	input  logic [WW-1:0]       eff_w,
	input  logic [HW-1:0]       eff_h,
	output logic [AW-1:0]       addr,
	output logic                in_img
);
	import bdil_pkg::*;

	localparam int RW = ROW_W + 1;	// room for row+1
	localparam int CW = COL_W + 1;

	logic [RW-1:0] r;
	logic [CW-1:0] c;

	assign in_img = (int'(req.row) < int'(eff_h)) && (int'(req.col) < int'(eff_w));

	always_comb begin
		case (req.dr)
			OFS_NEG:  r = (req.row == '0) ? '0 : RW'(req.row) - RW'(1);
			OFS_POS:  r = (int'(req.row) + 1 >= int'(eff_h)) ? RW'(req.row)
			                                                  : RW'(req.row) + RW'(1);
			default:  r = RW'(req.row);
		endcase
		case (req.dc)
			OFS_NEG:  c = (req.col == '0) ? '0 : CW'(req.col) - CW'(1);
			OFS_POS:  c = (int'(req.col) + 1 >= int'(eff_w)) ? CW'(req.col)
			                                                  : CW'(req.col) + CW'(1);
			default:  c = CW'(req.col);
		endcase
	end

	assign addr = AW'(int'(r) * MAX_WIDTH + int'(c));

endmodule

/* rtl/core/bdil_store.sv */
// ----------------------------------------------------------------------------
// bdil_store
// Single-port foreground bit store with registered read data.
// ----------------------------------------------------------------------------
module bdil_store #(
	parameter int DEPTH = bdil_pkg::DEF_MAX_WIDTH * bdil_pkg::DEF_MAX_HEIGHT,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic               clk,
	input  bdil_pkg::mem_req_t req,
	input  logic [AW-1:0]      addr,
	output logic               rdata
);
	logic mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[addr] <= req.wbit;
		end
		if (req.re) begin
			rdata <= mem[addr];
		end
	end

endmodule

/* rtl/core/bdil_ctrl.sv */
// ----------------------------------------------------------------------------
// bdil_ctrl
// Sequencer: takes transactions, walks the nine neighbours of a query
// through the shared address unit and holds the result register.
// ----------------------------------------------------------------------------
module bdil_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	bdil_in_if.sink              in_ch,
	bdil_out_if.source           out_ch,
	input  logic                 in_img,
	input  logic                 rdata,
	output bdil_pkg::addr_req_t  areq,
	output bdil_pkg::mem_req_t   mreq
);
	import bdil_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_READ = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t           state_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	ofs_t             dr_q;
	ofs_t             dc_q;
	logic             hit_q;
	logic             rd_s1;
	logic             out_valid_q;
	logic [DIL_W-1:0] dilated_q;

	logic accept;
	logic is_query;
	logic hit_now;
	logic load_out;
	logic last_step;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign is_query    = (cmd_t'(in_ch.cmd) == CMD_QUERY);
	assign hit_now     = hit_q || (rd_s1 && rdata);
	assign load_out    = (state_q == ST_DONE) && (!out_valid_q || out_ch.ready);
	assign last_step   = (dr_q == OFS_POS) && (dc_q == OFS_POS);

	assign out_ch.valid   = out_valid_q;
	assign out_ch.dilated = dilated_q;

	// idle: centre pixel of the incoming item; busy: current neighbour
	always_comb begin
		if (state_q == ST_IDLE) begin
			areq = '{row: in_ch.row, col: in_ch.col, dr: OFS_ZERO, dc: OFS_ZERO};
		end else begin
			areq = '{row: row_q, col: col_q, dr: dr_q, dc: dc_q};
		end
		mreq.we   = accept && !is_query && in_img;
		mreq.re   = (state_q == ST_READ);
		mreq.wbit = (in_ch.pixel == FG_PIXEL);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_q <= in_ch.row;
			col_q <= in_ch.col;
		end
		if (load_out) begin
			dilated_q <= hit_now ? DIL_FG : DIL_BG;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			dr_q        <= OFS_NEG;
			dc_q        <= OFS_NEG;
			hit_q       <= 1'b0;
			rd_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_s1 <= mreq.re;
			if (rd_s1) begin
				hit_q <= hit_now;
			end

			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					dr_q  <= OFS_NEG;
					dc_q  <= OFS_NEG;
					hit_q <= 1'b0;
					if (accept && is_query) begin
						state_q <= in_img ? ST_READ : ST_DONE;
					end
				end
				ST_READ: begin
					if (last_step) begin
						state_q <= ST_DONE;
					end
					case (dc_q)
						OFS_NEG:  dc_q <= OFS_ZERO;
						OFS_ZERO: dc_q <= OFS_POS;
						default: begin
							dc_q <= OFS_NEG;
							case (dr_q)
								OFS_NEG:  dr_q <= OFS_ZERO;
								OFS_ZERO: dr_q <= OFS_POS;
								default:  dr_q <= OFS_NEG;
							endcase
						end
					endcase
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
